### design/evg_pkg.sv
// Package for the touch event generator: payload structs, event kinds,
// width constants and the gesture mapping. No dependencies.
`timescale 1ns / 1ps

package evg_pkg;

   localparam int SENSOR_W = 12;           // sensor coordinate width
   localparam int DIM_W = 12;              // display dimension width
   localparam int PROD_W = SENSOR_W + DIM_W;
   localparam int POS_W = 16;              // display coordinate width
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int DEF_DISPLAY_WIDTH = 320;
   localparam int DEF_DISPLAY_HEIGHT = 172;

   localparam logic [7:0] GEST_SLIDE_UP = 8'd1;
   localparam logic [7:0] GEST_SLIDE_DOWN = 8'd2;
   localparam logic [7:0] GEST_DOUBLE = 8'd11;
   localparam logic [7:0] GEST_LONG = 8'd12;

   typedef enum logic [2:0] {
      KIND_DOWN = 3'd0,
      KIND_MOVE = 3'd1,
      KIND_UP = 3'd2,
      KIND_SWIPE_LEFT = 3'd3,
      KIND_SWIPE_RIGHT = 3'd4,
      KIND_LONG_PRESS = 3'd5,
      KIND_DOUBLE_CLICK = 3'd6,
      KIND_NONE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      PH_TOUCH = 2'b01,
      PH_GEST = 2'b10
   } phase_type;

   typedef struct packed {
      logic [7:0] gesture_code;
      logic [7:0] finger_count;
      logic [7:0] sensor_x_high;
      logic [7:0] sensor_x_low;
      logic [7:0] sensor_y_high;
      logic [7:0] sensor_y_low;
   } req_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic last_of_run;
   } rsp_type;

   // One classified report as it waits between the front and back parts.
   typedef struct packed {
      logic touch;
      kind_type gest_kind;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } entry_type;

   function automatic kind_type gesture_kind(input logic [7:0] code);
      kind_type k;
      case (code)
         GEST_SLIDE_UP: k = KIND_SWIPE_LEFT;
         GEST_SLIDE_DOWN: k = KIND_SWIPE_RIGHT;
         GEST_LONG: k = KIND_LONG_PRESS;
         GEST_DOUBLE: k = KIND_DOUBLE_CLICK;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

### design/touch_event_generator_top.sv
// Touch event generator top level: front scaler pipeline, report queue and
// event back end. Uses evg_pkg, evg_front, evg_queue and evg_back.
//
//   Channel   Ports                              Moves
//   req       req_valid, req_stall, req_data     one touch report per item
//   rsp       rsp_valid, rsp_stall, rsp_data     one touch or gesture event per item
//
// A report is taken every cycle while the queue has room; the front scaler has
// three register stages, followed by the queue and the back end's output register.
// While rsp is not stalled the back end gives one event per cycle; a report with
// both a touch and a gesture event holds the queue head until both are sent.
// Reset is synchronous and empties the pipeline, the queue and the output register.
// Stalls on rsp back up through the queue into req_stall.
`timescale 1ns / 1ps

module touch_event_generator_top
   import evg_pkg::*;
#(
   parameter int DISPLAY_WIDTH = DEF_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   logic push, pop, q_full, q_valid;
   entry_type push_data, head;

   evg_front #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .push(push),
      .push_data(push_data),
      .q_full(q_full)
   );

   evg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .head(head),
      .not_empty(q_valid),
      .full(q_full)
   );

   evg_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .q_valid(q_valid),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

### design/evg_scale.sv
// One axis of the coordinate scaler: v * MUL / DIV, truncated to 16 bits.
// Uses evg_pkg. The division is a multiply by a fixed reciprocal plus one correction.
`timescale 1ns / 1ps

module evg_scale
   import evg_pkg::*;
#(
   parameter int MUL = DEF_DISPLAY_WIDTH,
   parameter int DIV = DEF_DISPLAY_HEIGHT
) (
   input logic clock,
   input logic [2:0] en,
   input logic [SENSOR_W-1:0] v,
   output logic [POS_W-1:0] q
);

   localparam int RECIP_W = PROD_W + 1;
   localparam int WIDE_W = PROD_W + RECIP_W;
   localparam bit DIV_ZERO = (DIV == 0);
   localparam longint unsigned RECIP_L = DIV_ZERO ? 0 : ((64'd1 << PROD_W) / DIV);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   localparam logic [DIM_W-1:0] MUL_C = DIM_W'(MUL);
   localparam logic [PROD_W-1:0] DIV_C = PROD_W'(DIV);

   logic [PROD_W-1:0] na_ff, na_in;
   logic [PROD_W-1:0] nb_ff;
   logic [WIDE_W-1:0] p_ff, p_in;
   logic [PROD_W-1:0] nc_ff, qc_ff, m_ff, m_in;
   logic [PROD_W-1:0] q_est, r, q_fin;

   // The reciprocal is rounded down, so the estimate is low by at most one.
   assign na_in = PROD_W'(v) * PROD_W'(MUL_C);
   assign p_in = WIDE_W'(na_ff) * WIDE_W'(RECIP);
   assign q_est = p_ff[PROD_W +: PROD_W];
   assign m_in = q_est * DIV_C;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         na_ff <= na_in;
      end
      if (en[1]) begin
         nb_ff <= na_ff;
         p_ff <= p_in;
      end
      if (en[2]) begin
         nc_ff <= nb_ff;
         qc_ff <= q_est;
         m_ff <= m_in;
      end
   end

   // The product p_ff is taken from the same stage-one value that moves into nb_ff.
   assign r = nc_ff - m_ff;
   assign q_fin = qc_ff + PROD_W'(r >= DIV_C);
   assign q = DIV_ZERO ? '0 : q_fin[POS_W-1:0];

endmodule

### design/evg_front.sv
// Front part: accepts reports, classifies them and scales both axes in a
// three-stage pipeline. Uses evg_pkg and evg_scale.
`timescale 1ns / 1ps

module evg_front
   import evg_pkg::*;
#(
   parameter int DISPLAY_WIDTH = DEF_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic push,
   output entry_type push_data,
   input logic q_full
);

   logic [2:0] vld_ff, vld_in;
   logic [2:0] en;
   logic [2:0] touch_ff;
   kind_type gk_ff [3];
   logic [SENSOR_W-1:0] tx, ty;
   logic [POS_W-1:0] sx, sy;

   assign tx = {req_data.sensor_x_high[3:0], req_data.sensor_x_low};
   assign ty = {req_data.sensor_y_high[3:0], req_data.sensor_y_low};

   // A stage takes new data when it is empty or its contents move on.
   assign en[2] = !vld_ff[2] || !q_full;
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];
   assign req_stall = !en[0];

   assign vld_in[0] = en[0] ? req_valid : vld_ff[0];
   assign vld_in[1] = en[1] ? vld_ff[0] : vld_ff[1];
   assign vld_in[2] = en[2] ? vld_ff[1] : vld_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         touch_ff[0] <= (req_data.finger_count != 8'd0);
         gk_ff[0] <= gesture_kind(req_data.gesture_code);
      end
      if (en[1]) begin
         touch_ff[1] <= touch_ff[0];
         gk_ff[1] <= gk_ff[0];
      end
      if (en[2]) begin
         touch_ff[2] <= touch_ff[1];
         gk_ff[2] <= gk_ff[1];
      end
   end

   // The axes swap: display X comes from sensor Y and the other way round.
   evg_scale #(
      .MUL(DISPLAY_WIDTH),
      .DIV(DISPLAY_HEIGHT)
   ) u_scale_x (
      .clock(clock),
      .en(en),
      .v(ty),
      .q(sx)
   );

   evg_scale #(
      .MUL(DISPLAY_HEIGHT),
      .DIV(DISPLAY_WIDTH)
   ) u_scale_y (
      .clock(clock),
      .en(en),
      .v(tx),
      .q(sy)
   );

   assign push = vld_ff[2] && !q_full;
   assign push_data.touch = touch_ff[2];
   assign push_data.gest_kind = gk_ff[2];
   assign push_data.x = sx;
   assign push_data.y = sy;

endmodule

### design/evg_queue.sv
// Short queue of classified reports between the front and back parts.
// Uses evg_pkg.
`timescale 1ns / 1ps

module evg_queue
   import evg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input entry_type push_data,
   input logic pop,
   output entry_type head,
   output logic not_empty,
   output logic full
);

   entry_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0] cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != '0);
   assign full = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head = slot_ff[rd_ff];

   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### design/evg_back.sv
// Back part: tracks press state and last position, turns each queued report
// into up to two events and holds them in the output register. Uses evg_pkg.
`timescale 1ns / 1ps

module evg_back
   import evg_pkg::*;
(
   input logic clock,
   input logic reset,
   input entry_type head,
   input logic q_valid,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data
);

   logic pressed_ff, pressed_in;
   logic [POS_W-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   phase_type phase_ff, phase_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic out_free, go, has_gest, touch_hit;
   kind_type touch_kind;
   rsp_type touch_rsp, gest_rsp;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go = q_valid && out_free;
   assign has_gest = (head.gest_kind != KIND_NONE);

   // Contact gives DOWN or, if the position moved, MOVE; release gives UP once.
   assign touch_hit = head.touch ?
      (!pressed_ff || head.x != last_x_ff || head.y != last_y_ff) : pressed_ff;
   assign touch_kind = head.touch ? (pressed_ff ? KIND_MOVE : KIND_DOWN) : KIND_UP;

   assign touch_rsp.event_kind = touch_kind;
   assign touch_rsp.pos_x = head.touch ? head.x : last_x_ff;
   assign touch_rsp.pos_y = head.touch ? head.y : last_y_ff;
   assign touch_rsp.last_of_run = !has_gest;

   assign gest_rsp.event_kind = head.gest_kind;
   assign gest_rsp.pos_x = '0;
   assign gest_rsp.pos_y = '0;
   assign gest_rsp.last_of_run = 1'b1;

   always_comb begin
      pressed_in = pressed_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      phase_in = phase_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      pop = 1'b0;
      if (go) begin
         case (phase_ff)
            PH_TOUCH: begin
               pressed_in = head.touch;
               if (head.touch) begin
                  last_x_in = head.x;
                  last_y_in = head.y;
               end
               if (touch_hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = touch_rsp;
                  if (has_gest) begin
                     phase_in = PH_GEST;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  pop = 1'b1;
                  if (has_gest) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in = gest_rsp;
                  end
               end
            end
            PH_GEST: begin
               rsp_valid_in = 1'b1;
               rsp_data_in = gest_rsp;
               pop = 1'b1;
               phase_in = PH_TOUCH;
            end
            default: begin
               phase_in = PH_TOUCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         phase_ff <= PH_TOUCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         pressed_ff <= pressed_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### design/evg_checker.sv
// Port-level checks for the touch event generator, bound to the top level.
// Uses evg_pkg.
`timescale 1ns / 1ps

module evg_checker
   import evg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input req_type req_data,
   input logic rsp_valid,
   input logic rsp_stall,
   input rsp_type rsp_data
);

   // Nothing comes out in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Gesture events carry no position.
   a_gest_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind >= KIND_SWIPE_LEFT
         |-> rsp_data.pos_x == '0 && rsp_data.pos_y == '0)
      else $error("gesture event with a position");

   // Only a touch event can be followed by another event of the same report.
   a_non_last_is_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> rsp_data.event_kind <= KIND_UP)
      else $error("gesture event not marked last");

   // After a non-final event the next one from the same report is a gesture.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run ##1 rsp_valid
         |-> rsp_data.event_kind >= KIND_SWIPE_LEFT && rsp_data.last_of_run)
      else $error("second event of a report is not a final gesture");

endmodule

bind touch_event_generator_top evg_checker u_evg_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for touch_event_generator_top: drives touch reports,
// predicts DOWN/MOVE/UP and gesture events, and checks every event in order.
// Depends on evg_pkg and the touch_event_generator_top RTL.
`timescale 1ns / 1ps

module tb_top;
   import evg_pkg::*;

   localparam int DISPLAY_W = DEF_DISPLAY_WIDTH;
   localparam int DISPLAY_H = DEF_DISPLAY_HEIGHT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 20;

   // Raw gesture codes that the block maps to nothing.
   localparam logic [7:0] GEST_NO = 8'd0;
   localparam logic [7:0] GEST_LEFT = 8'd3;
   localparam logic [7:0] GEST_RIGHT = 8'd4;
   localparam logic [7:0] GEST_CLICK = 8'd5;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted touch state and the events still owed by the block.
   logic finger_on;
   logic [15:0] held_x;
   logic [15:0] held_y;
   rsp_type expected_events[$];

   int req_idle_pct;
   int rsp_idle_pct;
   int reports_sent;
   int touch_events;
   int gesture_events;
   int errors;
   int cycles;

   touch_event_generator_top #(
      .DISPLAY_WIDTH(DISPLAY_W),
      .DISPLAY_HEIGHT(DISPLAY_H)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic logic [15:0] scale_pos(input logic [11:0] v, input int mul,
                                             input int div);
      longint q;
      if (div == 0) begin
         return 16'd0;
      end
      q = (longint'(v) * mul) / div;
      return q[15:0];
   endfunction

   function automatic void predict_events(input req_type r);
      rsp_type ev[2];
      int n;
      logic [11:0] sx;
      logic [11:0] sy;
      logic [15:0] px;
      logic [15:0] py;
      kind_type gk;
      n = 0;
      sx = {r.sensor_x_high[3:0], r.sensor_x_low};
      sy = {r.sensor_y_high[3:0], r.sensor_y_low};
      // Axes are swapped on the way to the display.
      px = scale_pos(sy, DISPLAY_W, DISPLAY_H);
      py = scale_pos(sx, DISPLAY_H, DISPLAY_W);
      if (r.finger_count != 8'd0) begin
         if (!finger_on) begin
            ev[n] = {KIND_DOWN, px, py, 1'b0};
            n++;
         end else if (px != held_x || py != held_y) begin
            ev[n] = {KIND_MOVE, px, py, 1'b0};
            n++;
         end
         finger_on = 1'b1;
         held_x = px;
         held_y = py;
      end else if (finger_on) begin
         ev[n] = {KIND_UP, held_x, held_y, 1'b0};
         n++;
         finger_on = 1'b0;
      end
      case (r.gesture_code)
         GEST_SLIDE_UP: gk = KIND_SWIPE_LEFT;
         GEST_SLIDE_DOWN: gk = KIND_SWIPE_RIGHT;
         GEST_LONG: gk = KIND_LONG_PRESS;
         GEST_DOUBLE: gk = KIND_DOUBLE_CLICK;
         default: gk = KIND_NONE;
      endcase
      if (gk != KIND_NONE) begin
         ev[n] = {gk, 16'd0, 16'd0, 1'b0};
         n++;
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) begin
            ev[i].last_of_run = 1'b1;
         end
         expected_events.push_back(ev[i]);
      end
   endfunction

   // Builds a report with random junk in the ignored high nibbles.
   function automatic req_type make_report(input logic [7:0] gesture,
                                           input logic [7:0] fingers,
                                           input logic [11:0] sx,
                                           input logic [11:0] sy);
      req_type r;
      r.gesture_code = gesture;
      r.finger_count = fingers;
      r.sensor_x_high = {4'($urandom_range(15)), sx[11:8]};
      r.sensor_x_low = sx[7:0];
      r.sensor_y_high = {4'($urandom_range(15)), sy[11:8]};
      r.sensor_y_low = sy[7:0];
      return r;
   endfunction

   function automatic logic [7:0] random_gesture();
      logic [7:0] g;
      case ($urandom_range(9))
         4: g = GEST_SLIDE_UP;
         5: g = GEST_SLIDE_DOWN;
         6: g = GEST_LONG;
         7: g = GEST_DOUBLE;
         8: begin
            case ($urandom_range(2))
               0: g = GEST_LEFT;
               1: g = GEST_RIGHT;
               default: g = GEST_CLICK;
            endcase
         end
         9: g = 8'($urandom_range(255));
         default: g = GEST_NO;
      endcase
      return g;
   endfunction

   task automatic send_report(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_events(r);
      reports_sent++;
   endtask

   // Holds the sender off until every owed event has come out.
   task automatic drain_events();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type exp_ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $error("unexpected event: kind %0d x %0d y %0d last %0b",
                   rsp_data.event_kind, rsp_data.pos_x, rsp_data.pos_y,
                   rsp_data.last_of_run);
            errors++;
         end else begin
            exp_ev = expected_events.pop_front();
            if (rsp_data.event_kind != exp_ev.event_kind) begin
               $error("event_kind: expected %0d, got %0d", exp_ev.event_kind,
                      rsp_data.event_kind);
               errors++;
            end
            if (rsp_data.pos_x != exp_ev.pos_x) begin
               $error("pos_x: expected %0d, got %0d", exp_ev.pos_x, rsp_data.pos_x);
               errors++;
            end
            if (rsp_data.pos_y != exp_ev.pos_y) begin
               $error("pos_y: expected %0d, got %0d", exp_ev.pos_y, rsp_data.pos_y);
               errors++;
            end
            if (rsp_data.last_of_run != exp_ev.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", exp_ev.last_of_run,
                      rsp_data.last_of_run);
               errors++;
            end
            if (exp_ev.event_kind <= KIND_UP) begin
               touch_events++;
            end else begin
               gesture_events++;
            end
         end
      end
   end

   task automatic test_contact_and_release();
      send_report(make_report(GEST_NO, 8'd0, 12'd0, 12'd0));
      send_report(make_report(GEST_NO, 8'd1, 12'd0, 12'd0));
      send_report(make_report(GEST_NO, 8'd1, 12'd0, 12'd0));
      send_report(make_report(GEST_NO, 8'd0, 12'hFFF, 12'hFFF));
      send_report(make_report(GEST_NO, 8'd0, 12'd0, 12'd0));
   endtask

   task automatic test_position_extremes();
      req_type r;
      r = '1;
      r.gesture_code = GEST_NO;
      send_report(r);
      // Same position with the ignored nibbles cleared gives no MOVE.
      r.sensor_x_high = 8'h0F;
      r.sensor_y_high = 8'h0F;
      r.finger_count = 8'd1;
      send_report(r);
      send_report(make_report(GEST_NO, 8'd1, 12'd0, 12'hFFF));
      send_report(make_report(GEST_NO, 8'd1, 12'hFFF, 12'd0));
      send_report(make_report(GEST_NO, 8'd1, 12'd0, 12'd0));
      // A one-count sensor step scales to the same display pixel.
      send_report(make_report(GEST_NO, 8'd1, 12'd1, 12'd0));
      send_report(make_report(GEST_NO, 8'd0, 12'h800, 12'h7FF));
   endtask

   task automatic test_gesture_codes();
      logic [7:0] codes[8];
      codes = '{GEST_SLIDE_UP, GEST_SLIDE_DOWN, GEST_LONG, GEST_DOUBLE,
                GEST_LEFT, GEST_RIGHT, GEST_CLICK, 8'hFF};
      foreach (codes[i]) begin
         send_report(make_report(codes[i], 8'd0, 12'($urandom), 12'($urandom)));
      end
      send_report(make_report(GEST_SLIDE_UP, 8'd1, 12'd100, 12'd200));
      send_report(make_report(GEST_DOUBLE, 8'd3, 12'd300, 12'd400));
      send_report(make_report(GEST_LONG, 8'd0, 12'd5, 12'd6));
   endtask

   // Press, drag and release strokes with random content.
   task automatic test_touch_strokes(input int count);
      int stop_at;
      int presses;
      logic [11:0] sx;
      logic [11:0] sy;
      logic [7:0] fingers;
      stop_at = reports_sent + count;
      while (reports_sent < stop_at) begin
         sx = 12'($urandom);
         sy = 12'($urandom);
         presses = $urandom_range(1, 8);
         for (int i = 0; i < presses; i++) begin
            case ($urandom_range(3))
               0: ;
               1: begin
                  sx = sx + 12'($urandom_range(6)) - 12'd3;
                  sy = sy + 12'($urandom_range(6)) - 12'd3;
               end
               2: begin
                  sx = 12'($urandom);
                  sy = 12'($urandom);
               end
               default: begin
                  sx = $urandom_range(1) ? 12'hFFF : 12'd0;
                  sy = $urandom_range(1) ? 12'hFFF : 12'd0;
               end
            endcase
            fingers = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'd1;
            send_report(make_report(random_gesture(), fingers, sx, sy));
         end
         for (int i = $urandom_range(3) == 0 ? 2 : 1; i > 0; i--) begin
            send_report(make_report(random_gesture(), 8'd0, 12'($urandom),
                                    12'($urandom)));
         end
      end
   endtask

   task automatic test_report_noise(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r = req_type'({$urandom, 16'($urandom)});
         if ($urandom_range(2) == 0) begin
            r.finger_count = 8'd0;
         end
         send_report(r);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      finger_on = 1'b0;
      held_x = '0;
      held_y = '0;
      req_idle_pct = 38;
      rsp_idle_pct = 77;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_contact_and_release();
      test_position_extremes();
      test_gesture_codes();

      test_touch_strokes(500);
      test_report_noise(110);
      drain_events();

      req_idle_pct = 77;
      rsp_idle_pct = 38;
      test_touch_strokes(500);
      test_report_noise(110);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_touch_strokes(500);
      test_report_noise(110);

      drain_events();
      if (expected_events.size() != 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         errors++;
      end
      $display("tb: %0d reports sent over three stall mixes", reports_sent);
      $display("tb: %0d touch and %0d gesture events checked, %0d mismatches",
               touch_events, gesture_events, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
